// ===== design/mciir_pkg.sv =====
// Shared types and constants for the multichannel IIR filter.
package mciir_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int LANE_W    = 3;
  localparam int COEF_W    = 16;
  localparam int FRAC_W    = 12;
  localparam int CNT_W     = 3;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;
  localparam int PROD_W    = 2 * SAMPLE_W;
  localparam int ACC_W     = PROD_W + 5;
  localparam int Q_W       = ACC_W - FRAC_W;
  localparam int TAP_W     = 5;

  localparam logic signed [COEF_W-1:0] COEF_ONE   = 16'sh1000;
  localparam logic signed [ACC_W-1:0]  ROUND_HALF = ACC_W'(2048);
  localparam logic signed [Q_W-1:0]    Y_MAX      = Q_W'(32767);
  localparam logic signed [Q_W-1:0]    Y_MIN      = Q_W'(-32768);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FF_LOW  = 3'd0,
    CFG_FF_LAST = 3'd1,
    CFG_FB      = 3'd2,
    CFG_FF_CNT  = 3'd3,
    CFG_FB_CNT  = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    OP_XHIST,
    OP_NEW,
    OP_YHIST
  } op_kind_t;

  typedef struct packed {
    logic clr;
    logic vld;
    logic neg;
  } mac_ctl_t;

endpackage

// ===== design/mciir_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mciir_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/mciir_mac.sv =====
// Shared multiply-accumulate unit: registered product, then accumulate.
module mciir_mac
  import mciir_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  mac_ctl_t                 ctl,
  input  logic signed [SAMPLE_W-1:0] operand,
  input  logic signed [COEF_W-1:0] coef,
  output logic signed [ACC_W-1:0]  acc,
  output logic                     busy
);

  logic signed [PROD_W-1:0] prod_r;
  logic                     prod_v_r;
  logic                     prod_neg_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic signed [ACC_W-1:0]  prod_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
      acc_r    <= '0;
    end else begin
      prod_v_r <= ctl.vld;
      acc_r    <= acc_nxt;
    end
    prod_neg_r <= ctl.neg;
    if (ctl.vld) begin
      prod_r <= operand * coef;
    end
  end

  always_comb begin
    prod_ext = ACC_W'(prod_r);
    if (ctl.clr) begin
      acc_nxt = '0;
    end else if (prod_v_r) begin
      acc_nxt = prod_neg_r ? (acc_r - prod_ext) : (acc_r + prod_ext);
    end else begin
      acc_nxt = acc_r;
    end
  end

  assign acc  = acc_r;
  assign busy = prod_v_r;

endmodule

// ===== design/multichannel_iir_filter.sv =====
// Top level: multichannel direct-form-1 IIR filter on one shared MAC.
// An accepted word passes through the step sequencer, the operand stage, the MAC's product and
// accumulator registers and the result register before it shows on out_tvalid; the sequencer
// walks NUM_OPS = MAX_FF_TAPS + MAX_FB_TAPS - 1 steps. One word is in work at a time, set by the
// single multiplier and the one read port of each history RAM; every tap, used or not,
// takes one MAC slot. Reset: synchronous, active low; afterwards a clearing pass over
// every history address zeroes both histories (in_tready low).
module multichannel_iir_filter
  import mciir_pkg::*;
#(
  parameter int LANES       = 8,
  parameter int MAX_FF_TAPS = 5,
  parameter int MAX_FB_TAPS = 5
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration write port
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  // input stream
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [15:0]          in_tdata,   // [15:0] sample
  input  logic [2:0]           in_tuser,   // [2:0] lane
  // result stream
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [15:0]          out_tdata,  // [15:0] filtered
  output logic [3:0]           out_tuser   // [2:0] out_lane, [3] clipped
);

  localparam int YTAPS     = (MAX_FB_TAPS > 1) ? MAX_FB_TAPS - 1 : 1;
  localparam int XDEPTH    = LANES * MAX_FF_TAPS;
  localparam int YDEPTH    = LANES * YTAPS;
  localparam int XAW       = (XDEPTH > 1) ? $clog2(XDEPTH) : 1;
  localparam int YAW       = (YDEPTH > 1) ? $clog2(YDEPTH) : 1;
  localparam int SLOT_W    = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int NUM_OPS   = MAX_FF_TAPS + MAX_FB_TAPS - 1;
  localparam int STEP_W    = $clog2(NUM_OPS + 1);
  localparam int CLR_DEPTH = (XDEPTH > YDEPTH) ? XDEPTH : YDEPTH;
  localparam int CLR_W     = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;
  localparam int XJ_TOP    = MAX_FF_TAPS - 2;

  // Fold the lane number onto the state slots by repeated subtraction.
  function automatic logic [SLOT_W-1:0] lane_slot(input logic [LANE_W-1:0] l);
    logic [6:0] v;
    v = 7'(l);
    for (int i = 0; i < 8; i++) begin
      if (v >= 7'(LANES)) begin
        v = v - 7'(LANES);
      end
    end
    return SLOT_W'(v);
  endfunction

  // configuration registers
  logic [CFG_W-1:0]         ff_low_r;
  logic signed [COEF_W-1:0] ff_last_r;
  logic [CFG_W-1:0]         fb_r;
  logic [CNT_W-1:0]         ff_cnt_r;
  logic [CNT_W-1:0]         fb_cnt_r;

  // sequencer state
  state_t                   state_r, state_nxt;
  logic [STEP_W-1:0]        step_r, step_nxt;
  logic [CLR_W-1:0]         clr_cnt_r, clr_cnt_nxt;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic [SLOT_W-1:0]        slot_r;
  logic [LANE_W-1:0]        lane_r;

  // operand stage (RAM read data lines up with it)
  logic                     s1_v_r;
  op_kind_t                 s1_kind_r;
  logic [TAP_W-1:0]         s1_j_r;
  logic signed [COEF_W-1:0] s1_coef_r;

  // result register
  logic                     out_valid_r;
  logic [SAMPLE_W-1:0]      out_data_r;
  logic [LANE_W-1:0]        out_lane_r;
  logic                     out_clip_r;

  logic                     in_acc;
  logic                     out_acc;
  logic                     issue;
  logic                     fin_go;
  op_kind_t                 op_kind;
  logic [TAP_W-1:0]         op_j;
  logic [TAP_W-1:0]         op_tap;
  logic signed [COEF_W-1:0] op_coef;
  logic [TAP_W-1:0]         nb_eff;
  logic [TAP_W-1:0]         na_eff;
  logic [XAW-1:0]           x_base;
  logic [YAW-1:0]           y_base;

  logic                     x_we;
  logic [XAW-1:0]           x_waddr, x_raddr;
  logic [SAMPLE_W-1:0]      x_wdata, x_rdata;
  logic                     y_we;
  logic [YAW-1:0]           y_waddr, y_raddr;
  logic [SAMPLE_W-1:0]      y_wdata, y_rdata;

  mac_ctl_t                 mac_ctl;
  logic signed [SAMPLE_W-1:0] mac_operand;
  logic signed [ACC_W-1:0]  acc;
  logic                     mac_busy;
  logic signed [ACC_W-1:0]  rnd_sum;
  logic signed [Q_W-1:0]    rnd_q;
  logic [SAMPLE_W-1:0]      y_sat;
  logic                     y_clip;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_valid_r && out_tready;

  // Write configuration; only low bits of tap counts are kept.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ff_low_r  <= CFG_W'(COEF_ONE);
      ff_last_r <= '0;
      fb_r      <= '0;
      ff_cnt_r  <= CNT_W'(1);
      fb_cnt_r  <= CNT_W'(1);
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FF_LOW:  ff_low_r  <= cfg_wdata;
        CFG_FF_LAST: ff_last_r <= cfg_wdata[COEF_W-1:0];
        CFG_FB:      fb_r      <= cfg_wdata;
        CFG_FF_CNT:  ff_cnt_r  <= cfg_wdata[CNT_W-1:0];
        CFG_FB_CNT:  fb_cnt_r  <= cfg_wdata[CNT_W-1:0];
        default:     ;
      endcase
    end
  end

  // Clamp tap counts into 1..MAX.
  always_comb begin
    if (ff_cnt_r == '0) begin
      nb_eff = TAP_W'(1);
    end else if (TAP_W'(ff_cnt_r) > TAP_W'(MAX_FF_TAPS)) begin
      nb_eff = TAP_W'(MAX_FF_TAPS);
    end else begin
      nb_eff = TAP_W'(ff_cnt_r);
    end
    if (fb_cnt_r == '0) begin
      na_eff = TAP_W'(1);
    end else if (TAP_W'(fb_cnt_r) > TAP_W'(MAX_FB_TAPS)) begin
      na_eff = TAP_W'(MAX_FB_TAPS);
    end else begin
      na_eff = TAP_W'(fb_cnt_r);
    end
  end

  assign x_base = XAW'(slot_r) * XAW'(MAX_FF_TAPS);
  assign y_base = YAW'(slot_r) * YAW'(YTAPS);

  // Decode the step: first shift the input history oldest first, then take the
  // new sample, then walk the output history oldest first.
  always_comb begin
    issue = (state_r == ST_RUN) && (step_r != STEP_W'(NUM_OPS));
    if (step_r < STEP_W'(MAX_FF_TAPS - 1)) begin
      op_kind = OP_XHIST;
      op_j    = TAP_W'(XJ_TOP) - TAP_W'(step_r);
      op_tap  = op_j + TAP_W'(1);
    end else if (step_r == STEP_W'(MAX_FF_TAPS - 1)) begin
      op_kind = OP_NEW;
      op_j    = '0;
      op_tap  = '0;
    end else begin
      op_kind = OP_YHIST;
      op_j    = TAP_W'(NUM_OPS - 1) - TAP_W'(step_r);
      op_tap  = op_j + TAP_W'(1);
    end

    op_coef = '0;
    if (op_kind == OP_YHIST) begin
      if (op_tap < na_eff) begin
        case (op_tap)
          5'd1:    op_coef = fb_r[15:0];
          5'd2:    op_coef = fb_r[31:16];
          5'd3:    op_coef = fb_r[47:32];
          5'd4:    op_coef = fb_r[63:48];
          default: op_coef = '0;
        endcase
      end
    end else if (op_tap < nb_eff) begin
      case (op_tap)
        5'd0:    op_coef = ff_low_r[15:0];
        5'd1:    op_coef = ff_low_r[31:16];
        5'd2:    op_coef = ff_low_r[47:32];
        5'd3:    op_coef = ff_low_r[63:48];
        5'd4:    op_coef = ff_last_r;
        default: op_coef = '0;
      endcase
    end

    x_raddr = x_base + XAW'(op_j);
    y_raddr = y_base + YAW'(op_j);
  end

  // Round to nearest (ties up) and saturate.
  always_comb begin
    rnd_sum = acc + ROUND_HALF;
    rnd_q   = rnd_sum[ACC_W-1:FRAC_W];
    if (rnd_q > Y_MAX) begin
      y_sat  = Y_MAX[SAMPLE_W-1:0];
      y_clip = 1'b1;
    end else if (rnd_q < Y_MIN) begin
      y_sat  = Y_MIN[SAMPLE_W-1:0];
      y_clip = 1'b1;
    end else begin
      y_sat  = rnd_q[SAMPLE_W-1:0];
      y_clip = 1'b0;
    end
  end

  assign fin_go = (state_r == ST_FIN) && (!out_valid_r || out_tready);

  // History write ports: clearing pass, shift write-back, new entries.
  always_comb begin
    x_we    = 1'b0;
    x_waddr = x_base + XAW'(s1_j_r) + XAW'(1);
    x_wdata = x_rdata;
    y_we    = 1'b0;
    y_waddr = y_base + YAW'(s1_j_r) + YAW'(1);
    y_wdata = y_rdata;
    case (state_r)
      ST_CLEAR: begin
        x_we    = (clr_cnt_r <= CLR_W'(XDEPTH - 1));
        x_waddr = XAW'(clr_cnt_r);
        x_wdata = '0;
        y_we    = (clr_cnt_r <= CLR_W'(YDEPTH - 1));
        y_waddr = YAW'(clr_cnt_r);
        y_wdata = '0;
      end
      default: begin
        if (s1_v_r && s1_kind_r == OP_XHIST) begin
          x_we = 1'b1;
        end else if (s1_v_r && s1_kind_r == OP_NEW) begin
          x_we    = 1'b1;
          x_waddr = x_base;
          x_wdata = sample_r;
        end
        // drop the oldest output; it has no slot to move to
        if (s1_v_r && s1_kind_r == OP_YHIST && s1_j_r < TAP_W'(MAX_FB_TAPS - 2)) begin
          y_we = 1'b1;
        end else if (fin_go && (MAX_FB_TAPS > 1)) begin
          y_we    = 1'b1;
          y_waddr = y_base;
          y_wdata = y_sat;
        end
      end
    endcase
  end

  // Sequencer next state.
  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    clr_cnt_nxt = clr_cnt_r;
    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + CLR_W'(1);
        if (clr_cnt_r == CLR_W'(CLR_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        step_nxt = '0;
        if (in_acc) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (issue) begin
          step_nxt = step_r + STEP_W'(1);
        end else if (!s1_v_r && !mac_busy) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      step_r      <= '0;
      clr_cnt_r   <= '0;
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      step_r    <= step_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      s1_v_r    <= issue;
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sample_r <= in_tdata[SAMPLE_W-1:0];
      lane_r   <= in_tuser[LANE_W-1:0];
      slot_r   <= lane_slot(in_tuser[LANE_W-1:0]);
    end
    s1_kind_r <= op_kind;
    s1_j_r    <= op_j;
    s1_coef_r <= op_coef;
    if (fin_go) begin
      out_data_r <= y_sat;
      out_lane_r <= lane_r;
      out_clip_r <= y_clip;
    end
  end

  always_comb begin
    mac_ctl.clr = in_acc;
    mac_ctl.vld = s1_v_r;
    mac_ctl.neg = (s1_kind_r == OP_YHIST);
    case (s1_kind_r)
      OP_NEW:   mac_operand = sample_r;
      OP_YHIST: mac_operand = y_rdata;
      default:  mac_operand = x_rdata;
    endcase
  end

  mciir_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mac_ctl),
    .operand (mac_operand),
    .coef    (s1_coef_r),
    .acc     (acc),
    .busy    (mac_busy)
  );

  mciir_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (XDEPTH)
  ) u_xhist (
    .clk   (clk),
    .we    (x_we),
    .waddr (x_waddr),
    .wdata (x_wdata),
    .raddr (x_raddr),
    .rdata (x_rdata)
  );

  mciir_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (YDEPTH)
  ) u_yhist (
    .clk   (clk),
    .we    (y_we),
    .waddr (y_waddr),
    .wdata (y_wdata),
    .raddr (y_raddr),
    .rdata (y_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = {out_clip_r, out_lane_r};

endmodule

// ===== design/mciir_checker.sv =====
// Port-level checks on the multichannel IIR filter, bound to the top level.
module mciir_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [3:0]  out_tuser
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  // one word at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted again while a word is in work");

  // clearing pass follows reset
  a_clear_after_reset: assert property (@(posedge clk)
    $past(!rst_n) && rst_n |-> !in_tready)
    else $error("input ready before history clear");

  // a clipped result sits at a rail
  a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[3] |-> (out_tdata == 16'h7fff) || (out_tdata == 16'h8000))
    else $error("clipped flag set on a value off the rails");

endmodule

bind multichannel_iir_filter mciir_checker u_mciir_checker (.*);

// ===== verif/multichannel_iir_filter_test.sv =====
// Self-checking testbench for the multichannel IIR filter: directed table, then random words.
module multichannel_iir_filter_test;
  import mciir_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 7;
  localparam int N_LANES       = 8;
  localparam int FF_TAPS       = 5;
  localparam int FB_TAPS       = 5;
  // Leave margin past the result latency before touching registers.
  localparam int SETTLE_CYCLES = 24;
  // Cycles with no handshake on either side before the run is declared hung.
  localparam int STALL_LIMIT   = 3000;
  localparam int WORDS_PER_SET = 60;
  localparam int MAX_REPORTS   = 40;

  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;
  localparam longint ROUND_BIAS = 2048;
  localparam longint SAT_HI     = 32767;
  localparam longint SAT_LO     = -32768;

  // Coefficient styles for the random settings.
  localparam int STYLE_WILD    = 0;  // any code, counts out of range, junk in upper bits
  localparam int STYLE_EXTREME = 1;  // full-scale codes, all taps
  localparam int STYLE_GENTLE  = 2;  // small codes, mostly unsaturated output
  localparam int STYLE_FIR     = 3;  // no feedback

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] y;
    logic [LANE_W-1:0]          lane;
    logic                       clip;
  } lane_result_t;

  typedef struct packed {
    row_kind_t                  kind;
    logic [CFG_IDX_W-1:0]       idx;
    logic [CFG_W-1:0]           wdata;
    logic signed [SAMPLE_W-1:0] x_in;
    logic [LANE_W-1:0]          lane;
    logic                       has_typed;
    lane_result_t               typed_res;
  } plan_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [15:0]          in_tdata;   // [15:0] sample
  logic [2:0]           in_tuser;   // [2:0] lane
  logic                 out_tvalid;
  logic                 out_tready;
  logic [15:0]          out_tdata;  // [15:0] filtered
  logic [3:0]           out_tuser;  // [2:0] out_lane, [3] clipped

  // Shadow copy of the block's registers and per-lane histories (newest first).
  logic [CFG_W-1:0]           ff_low;
  logic signed [COEF_W-1:0]   ff_last;
  logic [CFG_W-1:0]           fb_coefs;
  logic [CNT_W-1:0]           ff_count;
  logic [CNT_W-1:0]           fb_count;
  logic signed [SAMPLE_W-1:0] x_hist [N_LANES][FF_TAPS];
  logic signed [SAMPLE_W-1:0] y_hist [N_LANES][FB_TAPS-1];

  lane_result_t pending_results[$];
  plan_row_t    plan[$];

  int send_idle_pct;
  int recv_stall_pct;
  int fail_count;
  int words_sent;
  int results_checked;
  int clip_results;
  int settings_done;
  int stall_cycles;
  lane_result_t want;

  multichannel_iir_filter u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // Run one sample through the shadow filter: shift it into the lane's input
  // history, sum both tap sets exactly, round half up, saturate, then push the
  // saturated value into the output history.
  function automatic void filter_word(input logic signed [SAMPLE_W-1:0] x_in,
                                      input logic [LANE_W-1:0] lane,
                                      output lane_result_t res);
    int nb;
    int na;
    int slot;
    int i;
    longint acc;
    longint q;
    logic signed [COEF_W-1:0] c;
    // Clamp tap counts: zero acts as one, anything past the maximum as the maximum.
    nb = (ff_count == 0) ? 1 : (ff_count > FF_TAPS) ? FF_TAPS : int'(ff_count);
    na = (fb_count == 0) ? 1 : (fb_count > FB_TAPS) ? FB_TAPS : int'(fb_count);
    slot = lane % N_LANES;
    for (i = FF_TAPS - 1; i >= 1; i--) x_hist[slot][i] = x_hist[slot][i-1];
    x_hist[slot][0] = x_in;
    acc = 0;
    for (i = 0; i < nb; i++) begin
      // Taps without a register field read as zero.
      if (i < 4) c = ff_low[16*i +: 16];
      else if (i == 4) c = ff_last;
      else c = '0;
      acc += longint'(c) * longint'(x_hist[slot][i]);
    end
    for (i = 1; i < na; i++) begin
      c = (i <= 4) ? fb_coefs[16*(i-1) +: 16] : '0;
      acc -= longint'(c) * longint'(y_hist[slot][i-1]);
    end
    q = (acc + ROUND_BIAS) >>> FRAC_W;
    res.clip = 1'b0;
    if (q > SAT_HI) begin
      q = SAT_HI;
      res.clip = 1'b1;
    end
    if (q < SAT_LO) begin
      q = SAT_LO;
      res.clip = 1'b1;
    end
    for (i = FB_TAPS - 2; i >= 1; i--) y_hist[slot][i] = y_hist[slot][i-1];
    y_hist[slot][0] = q[SAMPLE_W-1:0];
    res.y = q[SAMPLE_W-1:0];
    res.lane = lane;
  endfunction

  // Pick one Q3.12 coefficient code in the given style.
  function automatic logic [COEF_W-1:0] coef_code(input int style);
    logic [COEF_W-1:0] code;
    case (style)
      STYLE_EXTREME: begin
        case ($urandom_range(4))
          0: code = 16'h7FFF;
          1: code = 16'h8000;
          2: code = 16'h0000;
          3: code = COEF_ONE;
          default: code = 16'hF000;
        endcase
      end
      STYLE_GENTLE: code = 16'($urandom_range(2048)) - 16'd1024;
      default: code = 16'($urandom);
    endcase
    return code;
  endfunction

  // Mix full-scale random samples with small values and the rails.
  function automatic logic [SAMPLE_W-1:0] next_sample();
    logic [SAMPLE_W-1:0] s;
    case ($urandom_range(9))
      0, 1: s = 16'($urandom_range(512)) - 16'd256;
      2: begin
        case ($urandom_range(3))
          0: s = 16'h7FFF;
          1: s = 16'h8000;
          2: s = 16'h0000;
          default: s = 16'hFFFF;
        endcase
      end
      default: s = 16'($urandom);
    endcase
    return s;
  endfunction

  task automatic add_word(input int x_in, input int lane, input bit has_typed,
                          input int y, input bit clip);
    plan_row_t r;
    r = '0;
    r.kind = ROW_WORD;
    r.x_in = x_in[SAMPLE_W-1:0];
    r.lane = lane[LANE_W-1:0];
    r.has_typed = has_typed;
    r.typed_res.y = y[SAMPLE_W-1:0];
    r.typed_res.lane = lane[LANE_W-1:0];
    r.typed_res.clip = clip;
    plan = {plan, r};
  endtask

  task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] wdata);
    plan_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.idx = idx;
    r.wdata = wdata;
    plan = {plan, r};
  endtask

  // Drop valid, wait until every expected word has come back, then let the
  // pipeline go quiet.
  task automatic wait_drained();
    @(negedge clk) in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register while the block is idle and mirror it in the shadow copy.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] wdata);
    wait_drained();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= wdata;
    @(posedge clk);
    case (idx)
      CFG_FF_LOW:  ff_low = wdata;
      CFG_FF_LAST: ff_last = wdata[COEF_W-1:0];
      CFG_FB:      fb_coefs = wdata;
      CFG_FF_CNT:  ff_count = wdata[CNT_W-1:0];
      CFG_FB_CNT:  fb_count = wdata[CNT_W-1:0];
      default: ;  // unmapped index: the block ignores it
    endcase
    @(negedge clk) cfg_wr_en <= 1'b0;
  endtask

  // Offer one word, idling first at the current rate, and hold it until the
  // handshake completes. Valid stays high afterwards so back-to-back words
  // need no gap; the next call or wait_drained lowers it.
  task automatic send_word(input logic signed [SAMPLE_W-1:0] x_in,
                           input logic [LANE_W-1:0] lane,
                           input bit has_typed, input lane_result_t typed_res);
    lane_result_t res;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= x_in;
    in_tuser  <= lane;
    do @(posedge clk); while (!in_tready);
    filter_word(x_in, lane, res);
    if (has_typed) res = typed_res;
    pending_results = {pending_results, res};
    words_sent++;
  endtask

  // Load a full coefficient setting in one style.
  task automatic pick_setting(input int style);
    logic [COEF_W-1:0] b [5];
    logic [COEF_W-1:0] a [4];
    logic [CFG_W-1:0]  junk;
    logic [CNT_W-1:0]  nb;
    logic [CNT_W-1:0]  na;
    int i;
    for (i = 0; i < 5; i++) b[i] = coef_code(style);
    for (i = 0; i < 4; i++) a[i] = coef_code(style);
    junk = (style == STYLE_WILD) ? {$urandom, $urandom} : '0;
    case (style)
      STYLE_WILD: begin
        nb = CNT_W'($urandom_range(7));
        na = CNT_W'($urandom_range(7));
      end
      STYLE_EXTREME: begin
        nb = $urandom_range(1) ? CNT_W'(FF_TAPS) : 3'd7;
        na = $urandom_range(1) ? CNT_W'(FB_TAPS) : 3'd7;
      end
      STYLE_GENTLE: begin
        nb = CNT_W'($urandom_range(FF_TAPS, 1));
        na = CNT_W'($urandom_range(FB_TAPS, 1));
      end
      default: begin
        nb = CNT_W'($urandom_range(FF_TAPS, 1));
        na = 3'd1;
      end
    endcase
    write_reg(CFG_FF_LOW, {b[3], b[2], b[1], b[0]});
    write_reg(CFG_FF_LAST, {junk[CFG_W-1:COEF_W], b[4]});
    write_reg(CFG_FB, {a[3], a[2], a[1], a[0]});
    write_reg(CFG_FF_CNT, {junk[CFG_W-1:CNT_W], nb});
    write_reg(CFG_FB_CNT, {junk[CFG_W-1:CNT_W], na});
    if (style == STYLE_WILD)
      write_reg(CFG_IDX_W'($urandom_range(7, 5)), {$urandom, $urandom});
    settings_done++;
  endtask

  // Receiver: stall at the current rate, one decision per cycle.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Scoreboard: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: unexpected result: filtered %0d lane %0d clipped %0d", $time,
                   $signed(out_tdata), out_tuser[2:0], out_tuser[3]);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_tuser[3]) clip_results++;
        if (out_tdata !== want.y || out_tuser[2:0] !== want.lane ||
            out_tuser[3] !== want.clip) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: mismatch: expected filtered %0d lane %0d clipped %0d, got %0d %0d %0d",
                     $time, want.y, want.lane, want.clip,
                     $signed(out_tdata), out_tuser[2:0], out_tuser[3]);
        end
      end
    end
  end

  // Watchdog: count cycles with no handshake on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d results outstanding", $time,
               STALL_LIMIT, pending_results.size());
      $display("multichannel_iir_filter_test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    int i;
    int j;
    int phase;
    int set_no;
    int lane;
    lane_result_t dummy;

    // Hold every input at a known value and mirror the reset state.
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = '0;
    out_tready     = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fail_count     = 0;
    words_sent     = 0;
    results_checked = 0;
    clip_results   = 0;
    settings_done  = 0;
    stall_cycles   = 0;
    dummy          = '0;
    ff_low   = CFG_W'(COEF_ONE);
    ff_last  = '0;
    fb_coefs = '0;
    ff_count = 3'd1;
    fb_count = 3'd1;
    for (i = 0; i < N_LANES; i++) begin
      for (j = 0; j < FF_TAPS; j++) x_hist[i][j] = '0;
      for (j = 0; j < FB_TAPS - 1; j++) y_hist[i][j] = '0;
    end

    // Directed table. With reset coefficients the filter is a pass-through,
    // so the first rows have their results typed in.
    add_word(32767, 0, 1, 32767, 0);
    add_word(-32768, 7, 1, -32768, 0);
    add_word(0, 3, 1, 0, 0);
    add_word(-1, 5, 1, -1, 0);
    add_word(21845, 2, 1, 21845, 0);
    add_word(-21846, 6, 1, -21846, 0);
    // A write to an unmapped index must leave the pass-through alone.
    add_cfg(CFG_UNMAPPED, '1);
    add_word(1234, 4, 1, 1234, 0);
    // b0 just under +8.0: saturate at both rails, round small values.
    add_cfg(CFG_FF_LOW, 64'h7FFF);
    add_word(32767, 0, 1, 32767, 1);
    add_word(-32768, 1, 1, -32768, 1);
    add_word(1, 2, 1, 8, 0);
    add_word(-1, 3, 1, -8, 0);
    // b0 = -8.0: negative full scale flips past the top rail; 4096 lands exactly on the bottom rail.
    add_cfg(CFG_FF_LOW, 64'h8000);
    add_word(-32768, 4, 1, 32767, 1);
    add_word(4096, 5, 1, -32768, 0);
    // Unity on every feed-forward tap, count above the maximum: sums history.
    add_cfg(CFG_FF_LOW, 64'h1000_1000_1000_1000);
    add_cfg(CFG_FF_LAST, 64'h1000);
    add_cfg(CFG_FF_CNT, 64'd7);
    add_word(3000, 0, 0, 0, 0);
    add_word(3000, 0, 0, 0, 0);
    add_word(-32768, 1, 0, 0, 0);
    // Count of zero acts as one tap.
    add_cfg(CFG_FF_CNT, 64'd0);
    add_word(777, 0, 1, 777, 0);
    // Feedback coefficient loaded but count zero: still no feedback.
    add_cfg(CFG_FB, 64'h0800);
    add_cfg(CFG_FB_CNT, 64'd0);
    add_word(500, 2, 1, 500, 0);
    // Feedback count above the maximum acts as all taps; histories carry over.
    add_cfg(CFG_FB_CNT, 64'd6);
    add_word(1000, 2, 0, 0, 0);
    add_word(-1000, 2, 0, 0, 0);
    add_word(32767, 3, 0, 0, 0);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    // Hold off through the clearing pass.
    do @(posedge clk); while (!in_tready);

    for (i = 0; i < plan.size(); i++) begin
      if (plan[i].kind == ROW_CFG)
        write_reg(plan[i].idx, plan[i].wdata);
      else
        send_word(plan[i].x_in, plan[i].lane, plan[i].has_typed, plan[i].typed_res);
    end

    // Random part: four idling mixes, each over one setting of every style.
    lane = 0;
    for (phase = 0; phase < 4; phase++) begin
      wait_drained();
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      for (set_no = 0; set_no < 4; set_no++) begin
        pick_setting((set_no + phase) % 4);
        for (j = 0; j < WORDS_PER_SET; j++) begin
          // Pick a random lane most of the time; otherwise burst on one lane.
          if ($urandom_range(9) >= 3) lane = $urandom_range(N_LANES - 1);
          send_word(next_sample(), LANE_W'(lane), 0, dummy);
        end
      end
    end

    wait_drained();
    $display("Sent %0d words under %0d random coefficient settings plus the directed table,",
             words_sent, settings_done);
    $display("with four idling mixes; %0d results checked, %0d saturated.",
             results_checked, clip_results);
    if (fail_count == 0)
      $display("multichannel_iir_filter_test passed");
    else
      $display("multichannel_iir_filter_test failed");
    $finish;
  end

endmodule

// ===== files.f =====
design/mciir_pkg.sv
design/mciir_ram.sv
design/mciir_mac.sv
design/multichannel_iir_filter.sv
design/mciir_checker.sv
verif/multichannel_iir_filter_test.sv
